// File: rtl/gscr_pkg.sv
// Shared types, codes and a helper function of the gauge sample change recorder.
package gscr_pkg;

	// Item codes
	localparam logic MODE_OBSERVE = 1'b0;
	localparam logic MODE_READ    = 1'b1;

	// Configuration register select (word address bit)
	localparam logic REG_PERIOD   = 1'b0;
	localparam logic REG_DEADBAND = 1'b1;

	localparam logic [31:0] PERIOD_RESET   = 32'd30000000;
	localparam logic [14:0] DEADBAND_RESET = 15'd3;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		DIR_IDLE      = 2'd0,
		DIR_CHARGE    = 2'd1,
		DIR_DISCHARGE = 2'd2
	} dir_t;

	typedef struct packed {
		logic              mode;
		logic [6:0]        read_index;
		logic [62:0]       timestamp_us;
		logic              sample_valid;
		logic [15:0]       charge_percent;
		logic [15:0]       voltage_mv;
		logic signed [15:0] current_raw;
		logic [15:0]       design_capacity;
		logic [15:0]       gauge_status;
		logic [15:0]       gauge_flags;
		logic [15:0]       remaining_capacity;
		logic [15:0]       full_capacity;
	} req_t;

	typedef struct packed {
		logic              done_ok;
		logic [7:0]        entry_count;
		logic [62:0]       out_timestamp_us;
		logic              out_valid;
		logic [15:0]       out_charge;
		logic [15:0]       out_voltage;
		logic signed [15:0] out_current;
		logic [15:0]       out_design;
		logic [15:0]       out_status;
		logic [15:0]       out_flags;
		logic [15:0]       out_remaining;
		logic [15:0]       out_full;
	} rsp_t;

	// One stored sample
	typedef struct packed {
		logic [62:0]       timestamp;
		logic              valid;
		logic [15:0]       charge;
		logic [15:0]       voltage;
		logic signed [15:0] current;
		logic [15:0]       design_cap;
		logic [15:0]       status;
		logic [15:0]       flags;
		logic [15:0]       remaining;
		logic [15:0]       full;
	} entry_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic       is_read;
		logic [6:0] read_index;
		dir_t       dir;
		logic       charge_zero;
		entry_t     sample;
	} cmd_t;

	// Current direction with an idle band of +/- db around zero
	function automatic dir_t dir_of(input logic signed [15:0] cur, input logic [14:0] db);
		logic signed [16:0] c;
		logic signed [16:0] d;
		dir_t r;
		c = 17'(cur);
		d = signed'({2'b00, db});
		if (c > d) begin
			r = DIR_CHARGE;
		end else if (c < -d) begin
			r = DIR_DISCHARGE;
		end else begin
			r = DIR_IDLE;
		end
		return r;
	endfunction

endpackage

// File: rtl/gscr_front.sv
// Front end: accepts request transactions and classifies them for the back end.
module gscr_front (
	input  logic                req_valid,
	output logic                req_ready,
	input  gscr_pkg::req_t      req,
	input  logic [14:0]         deadband,
	output logic                push_valid,
	input  logic                push_ready,
	output gscr_pkg::cmd_t      push_cmd
);

	// Take a transaction whenever the queue has room
	assign req_ready  = push_ready;
	assign push_valid = req_valid;

	// Decode mode, direction and charge zero-ness; repack the sample
	always_comb begin
		push_cmd = '0;
		push_cmd.is_read            = (req.mode == gscr_pkg::MODE_READ);
		push_cmd.read_index         = req.read_index;
		push_cmd.dir                = gscr_pkg::dir_of(req.current_raw, deadband);
		push_cmd.charge_zero        = (req.charge_percent == 16'd0);
		push_cmd.sample.timestamp   = req.timestamp_us;
		push_cmd.sample.valid       = req.sample_valid;
		push_cmd.sample.charge      = req.charge_percent;
		push_cmd.sample.voltage     = req.voltage_mv;
		push_cmd.sample.current     = req.current_raw;
		push_cmd.sample.design_cap  = req.design_capacity;
		push_cmd.sample.status      = req.gauge_status;
		push_cmd.sample.flags       = req.gauge_flags;
		push_cmd.sample.remaining   = req.remaining_capacity;
		push_cmd.sample.full        = req.full_capacity;
	end

endmodule

// File: rtl/gscr_fifo.sv
// Short queue of classified commands between front and back.
module gscr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  gscr_pkg::cmd_t  push_cmd,
	output logic            pop_valid,
	input  logic            pop_ready,
	output gscr_pkg::cmd_t  pop_cmd
);

	localparam int PW = (gscr_pkg::QUEUE_DEPTH > 1) ? $clog2(gscr_pkg::QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(gscr_pkg::QUEUE_DEPTH + 1);

	gscr_pkg::cmd_t slot_q [gscr_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [FW-1:0]  fill_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (fill_q != FW'(gscr_pkg::QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(gscr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(gscr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/gscr_back.sv
// Back end: store decision, sample ring, entry reads and the response register.
module gscr_back #(
	parameter int HISTORY_DEPTH = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     period,
	input  logic [14:0]     deadband,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  gscr_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output gscr_pkg::rsp_t  rsp
);

	localparam int PW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam int SW = ((PW > 7) ? PW : 7) + 1;

	gscr_pkg::entry_t ring_mem [HISTORY_DEPTH];

	logic [PW-1:0]         wp_q;
	logic [CW-1:0]         count_q;
	logic [62:0]           last_time_q;
	logic                  last_valid_q;
	logic signed [15:0]    last_current_q;
	logic [15:0]           last_design_q;
	logic [15:0]           last_full_q;
	logic                  last_zero_q;

	logic                  v_s1;
	logic                  done_s1;
	logic                  rd_ok_s1;
	logic [CW-1:0]         cnt_s1;
	gscr_pkg::entry_t      rd_data_s1;

	logic                  rsp_valid_q;
	gscr_pkg::rsp_t        rsp_q;
	gscr_pkg::rsp_t        rsp_d;

	logic                  out_free;
	logic                  s1_free;
	logic                  pop;
	logic [62:0]           diff;
	logic                  later;
	logic                  changed;
	logic                  store;
	logic                  do_write;
	logic                  do_read;
	logic                  rd_ok;
	logic                  full;
	logic [CW-1:0]         count_next;
	logic [PW-1:0]         oldest;
	logic [SW-1:0]         slot_sum;
	logic [SW-1:0]         slot_wrap;
	logic [PW-1:0]         rd_slot;

	// Handshake between queue, access stage and response register
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign s1_free   = !v_s1 || out_free;
	assign cmd_ready = s1_free;
	assign pop       = cmd_valid && s1_free;

	// Decide whether an observed sample is stored: ring empty, or later than and different enough from the newest entry
	always_comb begin
		diff    = cmd.sample.timestamp - last_time_q;
		later   = (cmd.sample.timestamp > last_time_q);
		changed = (diff >= {31'd0, period})
			|| (cmd.sample.valid != last_valid_q)
			|| (cmd.sample.valid
				&& ((cmd.dir != gscr_pkg::dir_of(last_current_q, deadband))
				|| (cmd.sample.full != last_full_q)
				|| (cmd.sample.design_cap != last_design_q)
				|| (cmd.charge_zero != last_zero_q)));
		store   = (count_q == '0) || (later && changed);
	end

	assign full       = (count_q == CW'(HISTORY_DEPTH));
	assign do_write   = pop && !cmd.is_read && store;
	assign do_read    = pop && cmd.is_read;
	assign count_next = full ? count_q : count_q + 1'b1;
	assign rd_ok      = (XW'(cmd.read_index) < XW'(count_q));

	// Locate entry read_index counted from the oldest
	always_comb begin
		oldest    = full ? wp_q : '0;
		slot_sum  = SW'(oldest) + SW'(cmd.read_index);
		slot_wrap = (slot_sum >= SW'(HISTORY_DEPTH)) ? slot_sum - SW'(HISTORY_DEPTH) : slot_sum;
		rd_slot   = slot_wrap[PW-1:0];
	end

	// Ring write and registered ring read
	always_ff @(posedge clk) begin
		if (do_write) begin
			ring_mem[wp_q] <= cmd.sample;
		end
		if (do_read) begin
			rd_data_s1 <= ring_mem[rd_slot];
		end
	end

	// Keep a copy of the newest entry for the next comparison
	always_ff @(posedge clk) begin
		if (do_write) begin
			last_time_q    <= cmd.sample.timestamp;
			last_valid_q   <= cmd.sample.valid;
			last_current_q <= cmd.sample.current;
			last_design_q  <= cmd.sample.design_cap;
			last_full_q    <= cmd.sample.full;
			last_zero_q    <= cmd.charge_zero;
		end
	end

	// Advance write pointer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			count_q <= '0;
		end else if (do_write) begin
			wp_q    <= (wp_q == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			count_q <= count_next;
		end
	end

	// Access stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			done_s1  <= cmd.is_read ? rd_ok : store;
			rd_ok_s1 <= cmd.is_read && rd_ok;
			cnt_s1   <= (!cmd.is_read && store) ? count_next : count_q;
		end
	end

	// Assemble the response; entry fields stay zero unless a read hit
	always_comb begin
		rsp_d             = '0;
		rsp_d.done_ok     = done_s1;
		rsp_d.entry_count = 8'(cnt_s1);
		if (rd_ok_s1) begin
			rsp_d.out_timestamp_us = rd_data_s1.timestamp;
			rsp_d.out_valid        = rd_data_s1.valid;
			rsp_d.out_charge       = rd_data_s1.charge;
			rsp_d.out_voltage      = rd_data_s1.voltage;
			rsp_d.out_current      = rd_data_s1.current;
			rsp_d.out_design       = rd_data_s1.design_cap;
			rsp_d.out_status       = rd_data_s1.status;
			rsp_d.out_flags        = rd_data_s1.flags;
			rsp_d.out_remaining    = rd_data_s1.remaining;
			rsp_d.out_full         = rd_data_s1.full;
		end
	end

	// Response register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/gauge_sample_change_recorder.sv
// Top level of the gauge sample change recorder: register port, front, queue and back.
// Path: a request is registered in the queue, then in the access stage, then in the response register.
// Throughput: one transaction per cycle while rsp_ready holds, set by the single ring port in the back end
// (one write or one read per cycle) and the response register.
// Reset: configuration registers return to their defaults, pointer and entry count
// clear, queue and pipeline empty; ring contents stay undefined, with no clearing pass.
module gauge_sample_change_recorder #(
	parameter int HISTORY_DEPTH = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	input  logic            req_valid,
	output logic            req_ready,
	input  gscr_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output gscr_pkg::rsp_t  rsp
);

	logic [31:0]    period_q;
	logic [14:0]    deadband_q;
	logic           cfg_wr;
	logic           push_valid;
	logic           push_ready;
	gscr_pkg::cmd_t push_cmd;
	logic           pop_valid;
	logic           pop_ready;
	gscr_pkg::cmd_t pop_cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= gscr_pkg::PERIOD_RESET;
			deadband_q <= gscr_pkg::DEADBAND_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == gscr_pkg::REG_PERIOD) begin
				period_q <= pwdata;
			end else begin
				deadband_q <= pwdata[14:0];
			end
		end
	end

	// Register read-back
	assign prdata = (paddr[2] == gscr_pkg::REG_DEADBAND) ? {17'd0, deadband_q} : period_q;

	gscr_front u_front (
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.deadband   (deadband_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	gscr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	gscr_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.period    (period_q),
		.deadband  (deadband_q),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: verif/gauge_sample_change_recorder_tb.sv
// Self-checking testbench for the gauge sample change recorder: directed and random traffic.
module gauge_sample_change_recorder_tb;

	localparam int HISTORY_DEPTH = 128;
	localparam int ITEMS_PER_PHASE = 225;
	localparam int CYCLE_LIMIT = 400000;

	// Scoreboard: mirrors the ring and the register pair, queues expected responses
	class recorder_scoreboard;
		logic [31:0] period = gscr_pkg::PERIOD_RESET;
		logic [14:0] deadband = gscr_pkg::DEADBAND_RESET;
		gscr_pkg::entry_t ring[HISTORY_DEPTH];
		int unsigned head = 0;
		int unsigned held = 0;
		gscr_pkg::rsp_t pending[$];
		int unsigned errors = 0;

		function void set_register(logic sel, logic [31:0] value);
			if (sel == gscr_pkg::REG_PERIOD) begin
				period = value;
			end else begin
				deadband = value[14:0];
			end
		endfunction

		function gscr_pkg::dir_t heading(logic signed [15:0] cur);
			int c;
			int d;
			c = cur;
			d = deadband;
			if (c > d) return gscr_pkg::DIR_CHARGE;
			if (c < -d) return gscr_pkg::DIR_DISCHARGE;
			return gscr_pkg::DIR_IDLE;
		endfunction

		function logic [62:0] newest_time();
			if (held == 0) return '0;
			return ring[(head + HISTORY_DEPTH - 1) % HISTORY_DEPTH].timestamp;
		endfunction

		// Decide whether a sample differs enough from the newest stored one
		function bit worth_keeping(gscr_pkg::entry_t last, gscr_pkg::entry_t s);
			if (s.timestamp <= last.timestamp) return 1'b0;
			if (s.timestamp - last.timestamp >= {31'd0, period}) return 1'b1;
			if (s.valid != last.valid) return 1'b1;
			if (!s.valid) return 1'b0;
			if (heading(s.current) != heading(last.current)) return 1'b1;
			if (s.full != last.full) return 1'b1;
			if (s.design_cap != last.design_cap) return 1'b1;
			if ((s.charge == 16'd0) != (last.charge == 16'd0)) return 1'b1;
			return 1'b0;
		endfunction

		function void note_request(gscr_pkg::req_t r);
			gscr_pkg::rsp_t e;
			gscr_pkg::entry_t s;
			gscr_pkg::entry_t hit;
			int unsigned slot;
			bit keep;
			e = '0;
			if (r.mode == gscr_pkg::MODE_OBSERVE) begin
				s.timestamp = r.timestamp_us;
				s.valid = r.sample_valid;
				s.charge = r.charge_percent;
				s.voltage = r.voltage_mv;
				s.current = r.current_raw;
				s.design_cap = r.design_capacity;
				s.status = r.gauge_status;
				s.flags = r.gauge_flags;
				s.remaining = r.remaining_capacity;
				s.full = r.full_capacity;
				keep = (held == 0) ||
					worth_keeping(ring[(head + HISTORY_DEPTH - 1) % HISTORY_DEPTH], s);
				if (keep) begin
					ring[head] = s;
					head = (head + 1) % HISTORY_DEPTH;
					if (held < HISTORY_DEPTH) held++;
				end
				e.done_ok = keep;
				e.entry_count = 8'(held);
			end else begin
				e.entry_count = 8'(held);
				if (r.read_index < held) begin
					slot = (head + HISTORY_DEPTH - held + r.read_index) % HISTORY_DEPTH;
					hit = ring[slot];
					e.done_ok = 1'b1;
					e.out_timestamp_us = hit.timestamp;
					e.out_valid = hit.valid;
					e.out_charge = hit.charge;
					e.out_voltage = hit.voltage;
					e.out_current = hit.current;
					e.out_design = hit.design_cap;
					e.out_status = hit.status;
					e.out_flags = hit.flags;
					e.out_remaining = hit.remaining;
					e.out_full = hit.full;
				end
			end
			pending.push_back(e);
		endfunction

		function void compare_field(string field, logic [62:0] want, logic [62:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_response(gscr_pkg::rsp_t got);
			gscr_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("response transaction with no request outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			compare_field("done_ok", e.done_ok, got.done_ok);
			compare_field("entry_count", e.entry_count, got.entry_count);
			compare_field("out_timestamp_us", e.out_timestamp_us, got.out_timestamp_us);
			compare_field("out_valid", e.out_valid, got.out_valid);
			compare_field("out_charge", e.out_charge, got.out_charge);
			compare_field("out_voltage", e.out_voltage, got.out_voltage);
			compare_field("out_current", e.out_current, got.out_current);
			compare_field("out_design", e.out_design, got.out_design);
			compare_field("out_status", e.out_status, got.out_status);
			compare_field("out_flags", e.out_flags, got.out_flags);
			compare_field("out_remaining", e.out_remaining, got.out_remaining);
			compare_field("out_full", e.out_full, got.out_full);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic req_valid;
	logic req_ready;
	gscr_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	gscr_pkg::rsp_t rsp;

	recorder_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int unsigned cycle_count;
	gscr_pkg::req_t gauge;
	logic [62:0] clock_us;

	gauge_sample_change_recorder #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the response side at random
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Check every accepted response transaction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			sb.check_response(rsp);
		end
	end

	// Hard stop for a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_register(input logic sel, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(sel, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Present one request, with a random idle gap, and hold it until accepted
	task automatic send_request(input gscr_pkg::req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic gscr_pkg::req_t sample_at(logic [62:0] ts, logic ok,
			logic [15:0] charge, logic signed [15:0] cur, logic [15:0] design_cap,
			logic [15:0] full, logic [15:0] misc);
		gscr_pkg::req_t r;
		r = '0;
		r.mode = gscr_pkg::MODE_OBSERVE;
		r.timestamp_us = ts;
		r.sample_valid = ok;
		r.charge_percent = charge;
		r.current_raw = cur;
		r.design_capacity = design_cap;
		r.full_capacity = full;
		r.voltage_mv = misc;
		r.gauge_status = misc;
		r.gauge_flags = misc;
		r.remaining_capacity = misc;
		return r;
	endfunction

	function automatic gscr_pkg::req_t read_at(logic [6:0] idx);
		gscr_pkg::req_t r;
		r = '0;
		r.mode = gscr_pkg::MODE_READ;
		r.read_index = idx;
		return r;
	endfunction

	// Next sample of a slowly drifting gauge: mostly later times, occasional changes
	function automatic gscr_pkg::req_t next_observe();
		gscr_pkg::req_t r;
		int pick;
		int db;
		int c;
		logic [62:0] base;
		logic [62:0] ts;
		r = gauge;
		r.mode = gscr_pkg::MODE_OBSERVE;
		r.read_index = 7'($urandom);
		r.voltage_mv = 16'($urandom);
		r.gauge_status = 16'($urandom);
		r.gauge_flags = 16'($urandom);
		r.remaining_capacity = 16'($urandom);
		r.sample_valid = ($urandom_range(99) < 88);
		pick = $urandom_range(9);
		if (pick < 4) begin
			db = sb.deadband;
			c = int'($urandom_range(2 * db + 2)) - (db + 1);
			if (c > 32767) c = 32767;
			r.current_raw = 16'(c);
		end else if (pick < 6) begin
			r.current_raw = 16'($urandom);
		end
		if ($urandom_range(9) == 0) r.design_capacity = 16'($urandom);
		if ($urandom_range(9) == 0) r.full_capacity = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 15) begin
			r.charge_percent = 16'd0;
		end else if (pick < 30) begin
			r.charge_percent = 16'($urandom);
		end
		// Time: equal or earlier, around the period boundary, or a plain step forward
		base = sb.newest_time();
		pick = $urandom_range(99);
		if (pick < 8) begin
			ts = (base > 63'd3) ? base - 63'($urandom_range(3)) : base;
		end else if (pick < 20) begin
			ts = base + {31'd0, sb.period} - 63'd1 + 63'($urandom_range(2));
		end else if (pick < 85) begin
			ts = clock_us + 63'($urandom_range(1, 1000));
		end else begin
			ts = clock_us + 63'($urandom_range(1, 32'h0100_0000));
		end
		if (ts > clock_us) clock_us = ts;
		r.timestamp_us = ts;
		gauge = r;
		return r;
	endfunction

	function automatic gscr_pkg::req_t next_read();
		gscr_pkg::req_t r;
		r = gauge;
		r.mode = gscr_pkg::MODE_READ;
		if (sb.held > 0 && $urandom_range(9) < 7) begin
			r.read_index = 7'($urandom_range(sb.held - 1));
		end else begin
			r.read_index = 7'($urandom);
		end
		return r;
	endfunction

	initial begin
		sb = new;
		cycle_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		gauge = '0;
		clock_us = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at reset register values
		send_request(read_at(7'd0));
		send_request(sample_at(63'd0, 1'b0, 16'd0, 16'sd0, 16'd0, 16'd0, 16'd0));
		send_request(sample_at(63'd0, 1'b1, 16'd0, 16'sd0, 16'd0, 16'd0, 16'd0));
		send_request(sample_at(63'd5, 1'b1, 16'd0, 16'sd3, 16'd0, 16'd0, 16'd0));
		send_request(sample_at(63'd6, 1'b1, 16'd0, -16'sd3, 16'd0, 16'd0, 16'd0));
		send_request(sample_at(63'd7, 1'b1, 16'd0, 16'sd4, 16'd0, 16'd0, 16'd0));
		send_request(sample_at(63'd8, 1'b1, 16'd0, -16'sd4, 16'd0, 16'd0, 16'd0));
		send_request(sample_at(63'd9, 1'b1, 16'd0, 16'sh8000, 16'd0, 16'd0, 16'd0));
		send_request(sample_at(63'd10, 1'b1, 16'd0, 16'sh8000, 16'hFFFF, 16'd0, 16'd0));
		send_request(sample_at(63'd11, 1'b1, 16'd0, 16'sh8000, 16'hFFFF, 16'hFFFF,
			16'd0));
		send_request(sample_at(63'd12, 1'b1, 16'd1, 16'sh8000, 16'hFFFF, 16'hFFFF,
			16'd0));
		send_request(sample_at(63'd13, 1'b1, 16'hFFFF, 16'sh8000, 16'hFFFF, 16'hFFFF,
			16'd0));
		send_request(sample_at(63'd14, 1'b1, 16'hFFFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF));
		send_request(sample_at(63'd15, 1'b0, 16'hFFFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF));
		send_request(sample_at(63'd16, 1'b0, 16'd0, 16'sd0, 16'd0, 16'd0, 16'h5A5A));
		// Period boundary measured from the newest stored entry
		send_request(sample_at(63'd30000014, 1'b0, 16'd7, 16'sd0, 16'd0, 16'd0, 16'd0));
		send_request(sample_at(63'd30000015, 1'b0, 16'd7, 16'sd0, 16'd0, 16'd0, 16'd0));
		// Earlier time is dropped whatever else differs
		send_request(sample_at(63'd100, 1'b1, 16'd1, 16'sd100, 16'd1, 16'd1, 16'd1));
		send_request(read_at(7'd0));
		send_request(read_at(7'(sb.held - 1)));
		send_request(read_at(7'(sb.held)));
		send_request(read_at(7'h7F));
		drain();

		// Random phases, each with its own register setting and idling pattern
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_register(gscr_pkg::REG_PERIOD, 32'd1);
					write_register(gscr_pkg::REG_DEADBAND, 32'd0);
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					write_register(gscr_pkg::REG_PERIOD, 32'hFFFF_FFFF);
					write_register(gscr_pkg::REG_DEADBAND, 32'h7FFF);
					send_idle_pct = 74;
					stall_pct = 0;
				end
				2: begin
					write_register(gscr_pkg::REG_PERIOD, 32'($urandom_range(1, 5000)));
					write_register(gscr_pkg::REG_DEADBAND, 32'($urandom_range(40)));
					send_idle_pct = 0;
					stall_pct = 74;
				end
				default: begin
					write_register(gscr_pkg::REG_PERIOD, gscr_pkg::PERIOD_RESET);
					write_register(gscr_pkg::REG_DEADBAND, 32'(gscr_pkg::DEADBAND_RESET));
					send_idle_pct = 37;
					stall_pct = 37;
					// Jump far ahead so the upper time bits toggle
					clock_us = {2'b01, 61'({$urandom, $urandom}) >> 4};
				end
			endcase
			if (sb.newest_time() > clock_us) clock_us = sb.newest_time();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 75) begin
					send_request(next_observe());
				end else begin
					send_request(next_read());
				end
			end
			drain();
		end

		// Latest possible time, then read it back
		send_request(sample_at('1, 1'b1, 16'd5, 16'sd0, 16'd1, 16'd1, 16'd0));
		send_request(read_at(7'(sb.held - 1)));
		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
